FILE: src/jsfx_pkg.sv
// Shared types and constants for the JSON string field extractor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package jsfx_pkg;

    // Field name storage held in the two name registers.
    localparam int NAME_BYTES = 16;
    // Position counter width, enough for the deepest window at FIELD_MAX of 60.
    localparam int POS_W = 6;
    // Most results that one request can cause.
    localparam int MAX_RESULTS = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;
    localparam logic [1:0] REG_MAX_CHARS = 2'd3;

    // Characters that the scanner and decoder look for.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Byte classes.
    localparam logic [7:0] PRINT_LOW = 8'd32;
    localparam logic [7:0] DEL_CODE  = 8'd127;
    localparam logic [7:0] HIGH_LOW  = 8'd128;
    localparam logic [7:0] CONT_END  = 8'd192;

    // Result kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // One result item.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       found;
    } result_t;

    // All results caused by one request.
    typedef struct packed {
        logic [1:0]                   cnt;
        result_t [MAX_RESULTS-1:0]    ent;
    } group_t;

endpackage

FILE: src/jsfx_cell.sv
// One cell of the match window: holds one message byte and checks it against
// the pattern byte for its position. Depends on jsfx_pkg.
`timescale 1ns / 1ps

module jsfx_cell #(
    parameter int IDX = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic         clear,
    input  logic [7:0]   d_in,
    input  logic [127:0] name_chars,
    input  logic [4:0]   name_len,
    output logic [7:0]   q,
    output logic         hit
);

    localparam logic [jsfx_pkg::POS_W-1:0] POS = jsfx_pkg::POS_W'(IDX);

    logic [7:0]                 byte_reg;
    logic [jsfx_pkg::POS_W-1:0] end_pos;
    logic [jsfx_pkg::POS_W-1:0] name_idx;
    logic [7:0]                 want;
    logic                       care;

    // Pattern byte for this position, counted from the newest byte.
    // The pattern read newest first is quote, colon, quote, name reversed, quote.
    always_comb
    begin
        end_pos  = jsfx_pkg::POS_W'({1'b0, name_len}) + jsfx_pkg::POS_W'(3);
        name_idx = '0;
        care     = 1'b1;
        want     = jsfx_pkg::CH_QUOTE;
        if (IDX == 1)
        begin
            want = jsfx_pkg::CH_COLON;
        end
        else if (IDX >= 3)
        begin
            if (POS < end_pos)
            begin
                name_idx = end_pos - jsfx_pkg::POS_W'(1) - POS;
                if (name_idx < jsfx_pkg::POS_W'(jsfx_pkg::NAME_BYTES))
                begin
                    want = name_chars[{name_idx[3:0], 3'b000} +: 8];
                end
                else
                begin
                    want = 8'd0;
                end
            end
            else if (POS == end_pos)
            begin
                want = jsfx_pkg::CH_QUOTE;
            end
            else
            begin
                care = 1'b0;
            end
        end
    end

    // The check looks at the byte that enters this cell on the current shift.
    assign hit = !care || (d_in == want);
    assign q   = byte_reg;

    // Window storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (clear)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= d_in;
        end
    end

endmodule

FILE: src/jsfx_outq.sv
// Result queue: holds the results of up to two requests and hands them out
// one per cycle while res_ready is high. Depends on jsfx_pkg.
`timescale 1ns / 1ps

module jsfx_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsfx_pkg::group_t  push_group,
    output logic              full,
    output logic              res_valid,
    output jsfx_pkg::result_t res,
    output logic              res_last,
    input  logic              res_ready
);

    jsfx_pkg::group_t head_reg, head_next;
    jsfx_pkg::group_t tail_reg, tail_next;
    logic             head_v_reg, head_v_next;
    logic             tail_v_reg, tail_v_next;
    logic [1:0]       idx_reg, idx_next;

    // Current result of the head group.
    assign res       = head_reg.ent[idx_reg];
    assign res_last  = (idx_reg == (head_reg.cnt - 2'd1));
    assign res_valid = head_v_reg;
    assign full      = tail_v_reg;

    // Pop one result, then take in the new group behind what remains.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        head_v_next = head_v_reg;
        tail_v_next = tail_v_reg;
        idx_next    = idx_reg;
        if (head_v_reg && res_ready)
        begin
            if (res_last)
            begin
                idx_next    = '0;
                head_next   = tail_reg;
                head_v_next = tail_v_reg;
                tail_v_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (push)
        begin
            if (!head_v_next)
            begin
                head_next   = push_group;
                head_v_next = 1'b1;
            end
            else
            begin
                tail_next   = push_group;
                tail_v_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            tail_v_reg <= tail_v_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: src/json_string_field_extractor.sv
// Top level of the JSON string field extractor: configuration registers,
// copy decoder and phase control. Depends on jsfx_pkg, jsfx_cell, jsfx_outq.
`timescale 1ns / 1ps

// The block takes one message byte per request and looks for the first
// quote, field name, quote, colon, quote in a row of FIELD_MAX+4 window
// cells that compare and shift on each byte taken while searching, then decodes the
// string value that follows. A request is taken every cycle as long as each
// byte causes at most one result and results are taken when offered; a byte
// that causes two or three results hands them out one after another, and the
// two-entry result queue stops taking requests only when it is full. There is
// no clearing pass after reset. Results are registered in the result queue.
module json_string_field_extractor #(
    parameter int FIELD_MAX = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Byte requests.
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_req,
    input  logic        message_end,
    // Results.
    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [7:0]  value,
    output logic        found,
    output logic        run_end
);

    localparam int WIN_DEPTH = FIELD_MAX + 4;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COPY,
        PH_DONE
    } phase_t;

    // Configuration registers.
    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;
    logic [4:0]  name_len_reg;
    logic [7:0]  max_chars_reg;

    // Message state.
    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic       skip_reg, skip_next;
    logic [7:0] chars_reg, chars_next;

    logic                 accept;
    logic                 q_full;
    logic                 win_shift;
    logic                 win_clear;
    logic                 win_match;
    logic [7:0]           win_d [WIN_DEPTH];
    logic [7:0]           win_q [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] win_hit;

    jsfx_pkg::group_t  grp;
    jsfx_pkg::result_t res;

    // Decode scratch.
    logic       fresh;
    logic       unknown_esc;
    logic [7:0] char_a;
    logic [7:0] char_b;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign win_shift  = accept && (phase_reg == PH_SEARCH);
    assign win_clear  = accept && message_end;

    // Match window: a row of cells, newest byte in cell 0.
    genvar k;
    generate
        for (k = 0; k < WIN_DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign win_d[k] = byte_req;
            end
            else
            begin : g_link
                assign win_d[k] = win_q[k-1];
            end
            jsfx_cell #(
                .IDX(k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (win_shift),
                .clear      (win_clear),
                .d_in       (win_d[k]),
                .name_chars ({name_high_reg, name_low_reg}),
                .name_len   (name_len_reg),
                .q          (win_q[k]),
                .hit        (win_hit[k])
            );
        end
    endgenerate

    assign win_match = (&win_hit) && (int'(name_len_reg) <= FIELD_MAX);

    // Per-byte step: search, escape and continuation handling, limit and end.
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        skip_next   = skip_reg;
        chars_next  = chars_reg;
        grp         = '0;
        fresh       = 1'b0;
        unknown_esc = 1'b0;
        char_a      = jsfx_pkg::CH_BSLASH;
        char_b      = byte_req;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (win_match)
                begin
                    phase_next = PH_COPY;
                    if (chars_next >= max_chars_reg)
                    begin
                        grp.ent[grp.cnt] = '{jsfx_pkg::KIND_DONE, 8'd0, chars_next != 8'd0};
                        grp.cnt          = grp.cnt + 2'd1;
                        phase_next       = PH_DONE;
                    end
                end
            end
            PH_COPY:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    unique case (byte_req)
                        jsfx_pkg::CH_QUOTE:  char_a = jsfx_pkg::CH_QUOTE;
                        jsfx_pkg::CH_BSLASH: char_a = jsfx_pkg::CH_BSLASH;
                        jsfx_pkg::CH_N:      char_a = jsfx_pkg::CH_LF;
                        jsfx_pkg::CH_R:      char_a = jsfx_pkg::CH_CR;
                        jsfx_pkg::CH_T:      char_a = jsfx_pkg::CH_TAB;
                        default:
                        begin
                            char_a      = jsfx_pkg::CH_BSLASH;
                            unknown_esc = 1'b1;
                        end
                    endcase
                    grp.ent[grp.cnt] = '{jsfx_pkg::KIND_CHAR, char_a, 1'b0};
                    grp.cnt          = grp.cnt + 2'd1;
                    chars_next       = chars_next + 8'd1;
                    if (chars_next >= max_chars_reg)
                    begin
                        grp.ent[grp.cnt] = '{jsfx_pkg::KIND_DONE, 8'd0, 1'b1};
                        grp.cnt          = grp.cnt + 2'd1;
                        phase_next       = PH_DONE;
                    end
                    fresh = unknown_esc && (phase_next == PH_COPY);
                end
                else if (skip_reg)
                begin
                    if (!(byte_req >= jsfx_pkg::HIGH_LOW && byte_req < jsfx_pkg::CONT_END))
                    begin
                        skip_next = 1'b0;
                        fresh     = 1'b1;
                    end
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // A byte taken as a new character of the value.
        if (fresh)
        begin
            priority if (byte_req == jsfx_pkg::CH_BSLASH && !message_end)
            begin
                esc_next = 1'b1;
            end
            else if (byte_req == jsfx_pkg::CH_QUOTE)
            begin
                grp.ent[grp.cnt] = '{jsfx_pkg::KIND_DONE, 8'd0, 1'b1};
                grp.cnt          = grp.cnt + 2'd1;
                phase_next       = PH_DONE;
            end
            else
            begin
                if (byte_req < jsfx_pkg::PRINT_LOW || byte_req >= jsfx_pkg::DEL_CODE)
                begin
                    char_b = jsfx_pkg::CH_QMARK;
                end
                if (byte_req >= jsfx_pkg::HIGH_LOW)
                begin
                    skip_next = 1'b1;
                end
                grp.ent[grp.cnt] = '{jsfx_pkg::KIND_CHAR, char_b, 1'b0};
                grp.cnt          = grp.cnt + 2'd1;
                chars_next       = chars_next + 8'd1;
                if (chars_next >= max_chars_reg)
                begin
                    grp.ent[grp.cnt] = '{jsfx_pkg::KIND_DONE, 8'd0, 1'b1};
                    grp.cnt          = grp.cnt + 2'd1;
                    phase_next       = PH_DONE;
                end
            end
        end

        // Message end gives a done result unless one was already given, and starts over.
        if (message_end)
        begin
            if (phase_next != PH_DONE)
            begin
                grp.ent[grp.cnt] = '{jsfx_pkg::KIND_DONE, 8'd0, chars_next != 8'd0};
                grp.cnt          = grp.cnt + 2'd1;
            end
            phase_next = PH_SEARCH;
            esc_next   = 1'b0;
            skip_next  = 1'b0;
            chars_next = '0;
        end
    end

    // Message state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            esc_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            chars_reg     <= '0;
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= '0;
            max_chars_reg <= 8'd63;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                skip_reg  <= skip_next;
                chars_reg <= chars_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jsfx_pkg::REG_NAME_LOW:  name_low_reg  <= cfg_data;
                    jsfx_pkg::REG_NAME_HIGH: name_high_reg <= cfg_data;
                    jsfx_pkg::REG_NAME_LEN:  name_len_reg  <= cfg_data[4:0];
                    jsfx_pkg::REG_MAX_CHARS: max_chars_reg <= cfg_data[7:0];
                    default:                 name_len_reg  <= name_len_reg;
                endcase
            end
        end
    end

    // Result queue.
    jsfx_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && (grp.cnt != 2'd0)),
        .push_group (grp),
        .full       (q_full),
        .res_valid  (result_valid),
        .res        (res),
        .res_last   (run_end),
        .res_ready  (result_ready)
    );

    assign kind  = res.kind;
    assign value = res.value;
    assign found = res.found;

    // An escape can only be open while the value is being copied.
    a_esc_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg == PH_COPY))
        else $error("escape pending outside the copy phase");

    // Escape and continuation skipping never overlap.
    a_esc_skip: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && skip_reg))
        else $error("escape pending while skipping continuation bytes");

    // A full queue always has a result on offer.
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> result_valid)
        else $error("requests stalled with no result on offer");

    // The final byte of a message returns the message state to its start.
    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && message_end) |=> (phase_reg == PH_SEARCH && chars_reg == 8'd0
            && !esc_reg && !skip_reg))
        else $error("message state not cleared after the final byte");

endmodule
